// ----- hdl/grid_four_neighbour_peak_detect_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the grid peak detector
// Shared shorthand for concurrent checks clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef GRID_FOUR_NEIGHBOUR_PEAK_DETECT_DEFINES_SVH
`define GRID_FOUR_NEIGHBOUR_PEAK_DETECT_DEFINES_SVH

// Same-cycle implication.
`define GFPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gfpd assertion failed");

// Next-cycle implication.
`define GFPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("gfpd assertion failed");

`endif

// ----- hdl/gfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// gfpd_pkg
// Shared constants and types of the grid four-neighbor peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package gfpd_pkg;

  localparam int MaxSideDef    = 1024;
  localparam int SampleBitsDef = 16;
  localparam int GridW         = 11;
  localparam logic [GridW-1:0] GridReset = 11'd8;
  localparam int CoordW        = 10;
  localparam int ResFifoDepth  = 3;

  // Control from the sequencer to the window stage.
  typedef struct packed {
    logic clear;
    logic step;
  } gfpd_win_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/gfpd_ram.sv -----
// ----------------------------------------------------------------------------
// gfpd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gfpd_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/gfpd_window.sv -----
// ----------------------------------------------------------------------------
// gfpd_window
// Four-sample neighborhood around the pending center and its peak compare.
// ----------------------------------------------------------------------------
`default_nettype none

module gfpd_window
  import gfpd_pkg::*;
#(
  parameter int SampleBits = SampleBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire gfpd_win_ctrl_t               ctrl_i,
  input  wire logic signed [SampleBits-1:0] older_i,
  input  wire logic signed [SampleBits-1:0] newer_i,
  input  wire logic signed [SampleBits-1:0] sample_i,
  output logic signed      [SampleBits-1:0] centre_o,
  output logic                              is_peak_o
);

  logic signed [SampleBits-1:0] up_q, left_q, centre_q, below_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q     <= '0;
      left_q   <= '0;
      centre_q <= '0;
      below_q  <= '0;
    end else if (ctrl_i.clear) begin
      up_q     <= '0;
      left_q   <= '0;
      centre_q <= '0;
      below_q  <= '0;
    end else if (ctrl_i.step) begin
      up_q     <= older_i;
      left_q   <= centre_q;
      centre_q <= newer_i;
      below_q  <= sample_i;
    end
  end

  // The right neighbor is the entry of the row above read for this column.
  assign is_peak_o = (centre_q > up_q) && (centre_q > below_q) &&
                     (centre_q > left_q) && (centre_q > newer_i);
  assign centre_o  = centre_q;

endmodule

`default_nettype wire

// ----- hdl/gfpd_fifo.sv -----
// ----------------------------------------------------------------------------
// gfpd_fifo
// Small register FIFO that buffers reported peaks for the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module gfpd_fifo #(
  parameter int Width = 40,
  parameter int Depth = 3
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [Width-1:0]           push_data_i,
  input  wire logic                       pop_i,
  output logic                            valid_o,
  output logic      [Width-1:0]           data_o,
  output logic      [$clog2(Depth+1)-1:0] level_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int LvlW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]  level_q, level_d;
  logic             do_pop;

  assign do_pop = pop_i && (level_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      level_d = level_q + LvlW'(1);
    end else if (!push_i && do_pop) begin
      level_d = level_q - LvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

endmodule

`default_nettype wire

// ----- hdl/grid_four_neighbour_peak_detect.sv -----
// ----------------------------------------------------------------------------
// grid_four_neighbour_peak_detect
// Streams a square grid of signed samples in row-major order and reports each
// interior sample strictly greater than its up, down, left and right neighbors.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Request contents (lowest bit first)
//   s_axis    in         sample
//   m_axis    out        peak_value, peak_row, peak_column, zero padding
//   cfg       in         grid_size (write only, no handshake)
//
// One request is taken per clock cycle unless the input stalls. A result is
// decided in the second stage and then leaves the block through the result
// FIFO; the line store RAM is read when a sample is accepted and written back
// in the following cycle. Both row stores share one RAM word per column, so
// one read and one write port suffice for one sample per cycle. Results wait
// in a three-entry FIFO; the input stalls only while that FIFO, counting the
// sample still in the second stage, is full. Reset clears counters, window
// and FIFO; the RAM needs no clearing since an entry is only used after it
// was written in the current frame.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_four_neighbour_peak_detect
  import gfpd_pkg::*;
#(
  parameter int MaxSide    = MaxSideDef,
  parameter int SampleBits = SampleBitsDef
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  // Configuration: grid_size.
  input  wire logic                                       cfg_we_i,
  input  wire logic [GridW-1:0]                           cfg_wdata_i,
  // Input stream. tdata: sample.
  input  wire logic                                       s_axis_tvalid,
  output logic                                            s_axis_tready,
  input  wire logic [((SampleBits+7)/8)*8-1:0]            s_axis_tdata,
  // Output stream. tdata: peak_value, peak_row, peak_column, zero padding.
  output logic                                            m_axis_tvalid,
  input  wire logic                                       m_axis_tready,
  output logic [((SampleBits+2*CoordW+7)/8)*8-1:0]        m_axis_tdata
);

  localparam int SideW = $clog2(MaxSide + 1);
  localparam int ColW  = $clog2(MaxSide);
  localparam int OutW  = ((SampleBits + 2 * CoordW + 7) / 8) * 8;
  localparam int WordW = 2 * SampleBits;
  localparam int LvlW  = $clog2(ResFifoDepth + 1);

  // Configuration and position counters.
  logic [GridW-1:0] grid_q;
  logic [SideW-1:0] eff_side;
  logic [ColW-1:0]  row_q, row_d, col_q, col_d;
  logic             accept;
  logic             last_col;

  // Second stage: the sample whose line store read is returning.
  logic                         s2_valid_q;
  logic signed [SampleBits-1:0] s2_sample_q;
  logic [ColW-1:0]              s2_row_q, s2_col_q;
  logic                         fwd_q;
  logic [WordW-1:0]             fwd_word_q;

  logic [WordW-1:0]             ram_rdata, rd_word, wr_word;
  logic signed [SampleBits-1:0] above1, above2;
  logic                         fwd_d;

  gfpd_win_ctrl_t               win_ctrl;
  logic signed [SampleBits-1:0] centre;
  logic                         is_peak;
  logic                         interior;
  logic                         push;
  logic [OutW-1:0]              push_data;
  logic [LvlW-1:0]              fifo_level;

  // A zero size acts as one; sizes beyond the line store saturate.
  always_comb begin
    if (grid_q == '0) begin
      eff_side = SideW'(1);
    end else if (32'(grid_q) > 32'(MaxSide)) begin
      eff_side = SideW'(MaxSide);
    end else begin
      eff_side = SideW'(grid_q);
    end
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign last_col = (SideW'(col_q) + SideW'(1)) == eff_side;

  always_comb begin
    row_d = row_q;
    col_d = col_q + ColW'(1);
    if (last_col) begin
      col_d = '0;
      row_d = ((SideW'(row_q) + SideW'(1)) == eff_side) ? '0 : row_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GridReset;
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_we_i) begin
      // A new size restarts the frame.
      grid_q <= cfg_wdata_i;
      row_q  <= '0;
      col_q  <= '0;
    end else if (accept) begin
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  // When the same column is read while the second stage writes it (a one
  // sample wide grid), the freshly written word is forwarded instead.
  assign fwd_d = accept && s2_valid_q && (col_q == s2_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s2_valid_q <= accept;
      fwd_q      <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_sample_q <= s_axis_tdata[SampleBits-1:0];
      s2_row_q    <= row_q;
      s2_col_q    <= col_q;
    end
    fwd_word_q <= wr_word;
  end

  // RAM word per column: upper half is the row just above, lower half the
  // row two above.
  assign rd_word = fwd_q ? fwd_word_q : ram_rdata;
  assign above1  = rd_word[WordW-1:SampleBits];
  assign above2  = rd_word[SampleBits-1:0];
  assign wr_word = {s2_sample_q, above1};

  gfpd_ram #(
    .Width (WordW),
    .Depth (MaxSide)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s2_valid_q),
    .waddr_i (s2_col_q),
    .wdata_i (wr_word),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign win_ctrl.clear = cfg_we_i;
  assign win_ctrl.step  = s2_valid_q;

  gfpd_window #(
    .SampleBits (SampleBits)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .older_i   (above2),
    .newer_i   (above1),
    .sample_i  (s2_sample_q),
    .centre_o  (centre),
    .is_peak_o (is_peak)
  );

  // The window holds a full neighborhood only from the third row and the
  // third column on; the centre then sits one row up and one column left.
  assign interior = (s2_row_q > ColW'(1)) && (s2_col_q > ColW'(1));
  assign push     = s2_valid_q && interior && is_peak;

  always_comb begin
    push_data = '0;
    push_data[SampleBits-1:0] = centre;
    push_data[SampleBits+CoordW-1:SampleBits] = CoordW'(s2_row_q - ColW'(1));
    push_data[SampleBits+2*CoordW-1:SampleBits+CoordW] =
      CoordW'(s2_col_q - ColW'(1));
  end

  gfpd_fifo #(
    .Width (OutW),
    .Depth (ResFifoDepth)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (m_axis_tdata),
    .level_o     (fifo_level)
  );

  // Leave room for the sample in the second stage, which may still report.
  assign s_axis_tready =
    (32'(fifo_level) + 32'(s2_valid_q)) < 32'(ResFifoDepth);

endmodule

`default_nettype wire

// ----- hdl/gfpd_checker.sv -----
// ----------------------------------------------------------------------------
// gfpd_checker
// Port-level checks of the grid peak detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_four_neighbour_peak_detect_defines.svh"

module gfpd_checker
  import gfpd_pkg::*;
#(
  parameter int SampleBits = SampleBitsDef
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [((SampleBits+2*CoordW+7)/8)*8-1:0] m_axis_tdata
);

  logic out_stall;
  logic in_accept;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // A stalled result stays offered.
  `GFPD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid)

  // A stalled result keeps its contents.
  `GFPD_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(m_axis_tdata))

  // A result appearing on an idle output was decided by an earlier accepted sample.
  `GFPD_ASSERT_IMP(a_out_origin, clk_i, rst_ni, m_axis_tvalid && !$past(m_axis_tvalid), $past(in_accept, 2))

  // The input only stalls while buffered results wait.
  `GFPD_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)

endmodule

bind grid_four_neighbour_peak_detect gfpd_checker #(
  .SampleBits (SampleBits)
) u_gfpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
